>>> hdl/assert_macros.svh
// assertion macros used by the checker file
// needs nothing else; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, skipped while reset is high
`define SDLF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle, skipped while reset is high
`define SDLF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the next cycle, also checked across reset
`define SDLF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sdlf_pkg.sv
// shared types and constants of the shape dynamics logistic filter
// used by every module of the block; depends on nothing
`default_nettype none

package sdlf_pkg;

  localparam int WORD_W = 32;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = 61;
  localparam int DEN_W  = 32;
  localparam int QUO_W  = 31;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;

  // register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_INTERCEPT   = 3'd1;
  localparam logic [2:0] REG_COEF_FIRST  = 3'd2;
  localparam logic [2:0] REG_COEF_SECOND = 3'd3;
  localparam logic [2:0] REG_COEF_LAG    = 3'd4;
  localparam logic [2:0] REG_COEF_VOL    = 3'd5;
  localparam logic [2:0] REG_LOWER       = 3'd6;
  localparam logic [2:0] REG_UPPER       = 3'd7;

  // shock term forms
  localparam logic [2:0] MODE_SQUARED   = 3'd0;
  localparam logic [2:0] MODE_ABSOLUTE  = 3'd1;
  localparam logic [2:0] MODE_SIGNED_SQ = 3'd2;
  localparam logic [2:0] MODE_SIGNED_AB = 3'd3;

  localparam logic signed [31:0] UPPER_RESET = 32'sd65536;
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [45:0] EXP_LIMIT = 46'd23072094658;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd13;

  typedef struct packed {
    logic signed [31:0] z_prev;
    logic signed [31:0] h_prev;
  } item_t;

  typedef struct packed {
    logic signed [31:0] mapped_value;
    logic signed [31:0] raw_value;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed({{(PROD_W-31){1'b0}}, {31{1'b1}}})) begin
      r = 32'sh7fff_ffff;
    end else if (v < $signed({{(PROD_W-31){1'b1}}, {31{1'b0}}})) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sdlf_mul.sv
// shared signed multiplier with a registered product
// uses sdlf_pkg for operand widths
`default_nettype none

module sdlf_mul (
  input  wire logic                                clk,
  input  wire logic signed [sdlf_pkg::MUL_W-1:0]   a,
  input  wire logic signed [sdlf_pkg::MUL_W-1:0]   b,
  output logic signed [sdlf_pkg::PROD_W-1:0]       p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

>>> hdl/sdlf_div.sv
// restoring divider, one quotient bit per cycle
// uses sdlf_pkg for widths; quotient must fit QUO_W bits
`default_nettype none

module sdlf_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [sdlf_pkg::NUM_W-1:0]    num,
  input  wire logic [sdlf_pkg::DEN_W-1:0]    den,
  output logic                               busy,
  output logic [sdlf_pkg::QUO_W-1:0]         quo
);

  localparam int QW = sdlf_pkg::QUO_W;
  localparam int DW = sdlf_pkg::DEN_W;
  localparam int NW = sdlf_pkg::NUM_W;

  logic [DW-1:0]             rem;
  logic [DW-1:0]             den_q;
  logic [QW-1:0]             nsh;
  logic [$clog2(QW)-1:0]     cnt;
  logic [DW:0]               trial;
  logic [DW:0]               diff;

  assign trial = {rem, nsh[QW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem   <= {{(DW-(NW-QW)){1'b0}}, num[NW-1:QW]};
      nsh   <= num[QW-1:0];
      den_q <= den;
      cnt   <= ($clog2(QW))'(QW - 1);
      busy  <= 1'b1;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
      nsh <= {nsh[QW-2:0], 1'b0};
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sdlf_sqrt.sv
// digit-by-digit integer square root, one result bit per cycle
// uses sdlf_pkg for widths
`default_nettype none

module sdlf_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [sdlf_pkg::RAD_W-1:0]    radicand,
  output logic                               busy,
  output logic [sdlf_pkg::ROOT_W-1:0]        root
);

  localparam int RW = sdlf_pkg::RAD_W;
  localparam int OW = sdlf_pkg::ROOT_W;

  logic [RW-1:0]         x;
  logic [RW-1:0]         res;
  logic [RW-1:0]         bitv;
  logic [RW-1:0]         trial;
  logic [$clog2(OW)-1:0] cnt;

  assign trial = res + bitv;
  assign root  = res[OW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      x    <= radicand;
      res  <= '0;
      bitv <= {2'b01, {(RW-2){1'b0}}};
      cnt  <= ($clog2(OW))'(OW - 1);
      busy <= 1'b1;
    end else if (busy) begin
      if (x >= trial) begin
        x   <= x - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/shape_dynamics_logistic_filter.sv
// shape dynamics logistic filter: each input word (z_prev, h_prev) gives one result word
// (mapped_value, raw_value). raw = intercept + coef_first*f1(z) + coef_second*f2(z)
// + coef_lag*lag + coef_vol*sqrt(|h|), saturated to signed Q16.16 and kept as the new lag;
// mapped = lower_bound + (upper_bound - lower_bound) * sigmoid(raw). mode 4 to 7 is static:
// mapped is the intercept register, raw is the kept lag, nothing is updated. one word is in
// flight at a time and item_stall stays high until its result is loaded into the output
// register. item_stall is high for longer as |raw| grows toward 21.5, for less when |raw|
// is so large that exp underflows and the taylor series is skipped, and for least in static
// mode, and stays high while the result waits on a full, stalled output register. the cost
// is set by the bit-serial divider, which runs once per taylor term (13 times) and once for
// the sigmoid, and by the ln2 range reduction loop. all products go through one shared
// 33x33 multiplier. configuration writes only while idle.
// depends on sdlf_pkg, sdlf_mul, sdlf_div and sdlf_sqrt
`default_nettype none

module shape_dynamics_logistic_filter (
  input  wire logic              clk,
  input  wire logic              rst,
  // input word channel
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire sdlf_pkg::item_t   item,
  // result word channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output sdlf_pkg::result_t      result,
  // configuration write port
  input  wire logic              cfg_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);

  localparam int MW = sdlf_pkg::MUL_W;
  localparam int PW = sdlf_pkg::PROD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_T0, S_T1, S_T2, S_T3, S_VOL, S_T4, S_SAT, S_CHK, S_RED,
    S_TISS, S_TMUL, S_TDIV, S_CLAMP, S_SIGST, S_SIGDIV, S_MAP, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0]         mode;
  logic signed [31:0] intercept;
  logic signed [31:0] coef_first;
  logic signed [31:0] coef_second;
  logic signed [31:0] coef_lag;
  logic signed [31:0] coef_vol;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;

  // recursion state and working registers
  logic signed [31:0] lag;
  logic signed [31:0] z_r;
  logic signed [31:0] f1;
  logic signed [31:0] f2;
  logic signed [63:0] sum;
  logic [45:0]        x30;
  logic [4:0]         n;
  logic [29:0]        r;
  logic [30:0]        term;
  logic signed [32:0] acc;
  logic [3:0]         k;
  logic [30:0]        e;
  logic signed [31:0] mapped;

  // shared units
  logic signed [MW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [PW-1:0]  prod;
  logic                  div_start;
  logic [sdlf_pkg::NUM_W-1:0] div_num;
  logic [sdlf_pkg::DEN_W-1:0] div_den;
  logic                  div_busy;
  logic [sdlf_pkg::QUO_W-1:0] div_q;
  logic                  sqrt_start;
  logic [sdlf_pkg::RAD_W-1:0] sqrt_rad;
  logic                  sqrt_busy;
  logic [sdlf_pkg::ROOT_W-1:0] sqrt_root;

  logic                  item_take;
  logic                  out_load;
  logic [31:0]           habs;
  logic signed [PW-1:0]  prod_sh16;
  logic signed [PW-1:0]  prod_sh30;
  logic signed [63:0]    sum_add;
  logic signed [31:0]    raw_sat;
  logic [31:0]           raw_abs;
  logic signed [31:0]    sq;
  logic [31:0]           absz;
  logic [30:0]           acc_clamp;
  logic signed [32:0]    q_ext;
  logic signed [PW-1:0]  map_sum;

  sdlf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  sdlf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  sdlf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;

  // the finished word moves into the output register once that register is free
  assign out_load   = (state == S_OUT) && (!result_valid || !result_stall);

  // |h| with the most negative value giving 2^31
  assign habs       = item.h_prev[31] ? 32'(-item.h_prev) : item.h_prev;
  assign sqrt_rad   = {habs, 16'b0};
  assign sqrt_start = item_take && !mode[2];

  // square and magnitude of z, both saturated
  assign sq   = (|prod[PW-1:47]) ? 32'sh7fff_ffff : prod[47:16];
  assign absz = (z_r == 32'sh8000_0000) ? 32'h7fff_ffff :
                (z_r[31] ? 32'(-z_r) : z_r);

  assign prod_sh16 = prod >>> 16;
  assign prod_sh30 = prod >>> 30;
  assign sum_add   = sum + prod_sh16[63:0];
  assign raw_sat   = sdlf_pkg::sat32({{(PW-64){sum[63]}}, sum});
  assign raw_abs   = raw_sat[31] ? 32'(-raw_sat) : raw_sat;

  assign q_ext     = $signed({2'b00, div_q});
  assign acc_clamp = acc[32] ? 31'd0 :
                     (acc > $signed({2'b00, sdlf_pkg::Q30_ONE})) ? sdlf_pkg::Q30_ONE :
                     acc[30:0];
  assign map_sum   = prod_sh30 + {{(PW-32){lower_bound[31]}}, lower_bound};

  // operands of the shared multiplier per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        mul_a = {item.z_prev[31], item.z_prev};
        mul_b = {item.z_prev[31], item.z_prev};
      end
      S_T0: begin
        mul_a = {coef_first[31], coef_first};
        mul_b = {f1[31], f1};
      end
      S_T1: begin
        mul_a = {coef_second[31], coef_second};
        mul_b = {f2[31], f2};
      end
      S_T2: begin
        mul_a = {coef_lag[31], coef_lag};
        mul_b = {lag[31], lag};
      end
      S_VOL: begin
        mul_a = {coef_vol[31], coef_vol};
        mul_b = {{(MW-sdlf_pkg::ROOT_W){1'b0}}, sqrt_root};
      end
      S_TISS: begin
        mul_a = {2'b00, term};
        mul_b = {3'b000, r};
      end
      S_SIGDIV: begin
        mul_a = {upper_bound[31], upper_bound} - {lower_bound[31], lower_bound};
        mul_b = {2'b00, div_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider requests: taylor term over k, then the sigmoid quotient
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_TMUL) begin
      div_start = 1'b1;
      div_num   = {31'b0, prod[59:30]};
      div_den   = {28'b0, k};
    end else if (state == S_SIGST) begin
      div_start = 1'b1;
      div_num   = lag[31] ? {e, 30'b0} : {1'b1, 60'b0};
      div_den   = {1'b0, sdlf_pkg::Q30_ONE} + {1'b0, e};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      lag          <= '0;
      mode         <= '0;
      intercept    <= '0;
      coef_first   <= '0;
      coef_second  <= '0;
      coef_lag     <= '0;
      coef_vol     <= '0;
      lower_bound  <= '0;
      upper_bound  <= sdlf_pkg::UPPER_RESET;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          sdlf_pkg::REG_MODE:        mode        <= cfg_data[2:0];
          sdlf_pkg::REG_INTERCEPT:   intercept   <= cfg_data;
          sdlf_pkg::REG_COEF_FIRST:  coef_first  <= cfg_data;
          sdlf_pkg::REG_COEF_SECOND: coef_second <= cfg_data;
          sdlf_pkg::REG_COEF_LAG:    coef_lag    <= cfg_data;
          sdlf_pkg::REG_COEF_VOL:    coef_vol    <= cfg_data;
          sdlf_pkg::REG_LOWER:       lower_bound <= cfg_data;
          sdlf_pkg::REG_UPPER:       upper_bound <= cfg_data;
          default: ;
        endcase
      end

      // output register fills at the end of a word and drains independently of the sequencer
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_take) begin
            z_r <= item.z_prev;
            if (mode[2]) begin
              // static modes
              mapped <= intercept;
              state  <= S_OUT;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          case (mode)
            sdlf_pkg::MODE_SQUARED: begin
              f1 <= z_r;
              f2 <= sq;
            end
            sdlf_pkg::MODE_ABSOLUTE: begin
              f1 <= z_r;
              f2 <= absz;
            end
            sdlf_pkg::MODE_SIGNED_SQ: begin
              f1 <= z_r[31] ? sq : '0;
              f2 <= z_r[31] ? '0 : sq;
            end
            default: begin
              f1 <= z_r[31] ? absz : '0;
              f2 <= z_r[31] ? '0 : absz;
            end
          endcase
          state <= S_T0;
        end
        S_T0: begin
          sum   <= {{32{intercept[31]}}, intercept};
          state <= S_T1;
        end
        S_T1: begin
          sum   <= sum_add;
          state <= S_T2;
        end
        S_T2: begin
          sum   <= sum_add;
          state <= S_T3;
        end
        S_T3: begin
          sum   <= sum_add;
          state <= S_VOL;
        end
        S_VOL: begin
          // multiplier sees the root once the square root is finished
          if (!sqrt_busy) begin
            state <= S_T4;
          end
        end
        S_T4: begin
          sum   <= sum_add;
          state <= S_SAT;
        end
        S_SAT: begin
          lag   <= raw_sat;
          x30   <= {raw_abs, 14'b0};
          n     <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          // exp underflows to zero for 31 or more halvings
          if (x30 >= sdlf_pkg::EXP_LIMIT) begin
            e     <= '0;
            state <= S_SIGST;
          end else begin
            state <= S_RED;
          end
        end
        S_RED: begin
          // x = n*ln2 + r
          if (x30 >= {16'b0, sdlf_pkg::LN2_Q30}) begin
            x30 <= x30 - {16'b0, sdlf_pkg::LN2_Q30};
            n   <= n + 1'b1;
          end else begin
            r     <= x30[29:0];
            term  <= sdlf_pkg::Q30_ONE;
            acc   <= $signed({2'b00, sdlf_pkg::Q30_ONE});
            k     <= 4'd1;
            state <= S_TISS;
          end
        end
        S_TISS: begin
          state <= S_TMUL;
        end
        S_TMUL: begin
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (!div_busy) begin
            term <= div_q;
            // odd terms of exp(-r) are negative
            acc  <= k[0] ? (acc - q_ext) : (acc + q_ext);
            if (k == sdlf_pkg::TAYLOR_TERMS) begin
              state <= S_CLAMP;
            end else begin
              k     <= k + 1'b1;
              state <= S_TISS;
            end
          end
        end
        S_CLAMP: begin
          e     <= acc_clamp >> n;
          state <= S_SIGST;
        end
        S_SIGST: begin
          state <= S_SIGDIV;
        end
        S_SIGDIV: begin
          if (!div_busy) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          mapped <= sdlf_pkg::sat32(map_sum);
          state  <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            result.mapped_value <= mapped;
            result.raw_value    <= lag;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/sdlf_checker.sv
// port-level checks of the shape dynamics logistic filter, bound to the top level
// depends on sdlf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module sdlf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_stall,
  input wire sdlf_pkg::item_t   item,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire sdlf_pkg::result_t result
);

  // a held result keeps its value
  `SDLF_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "result word changed while stalled")

  // one word at a time: busy right after an accept
  `SDLF_ASSERT_NEXT(a_busy_after_take, clk, rst, item_valid && !item_stall, item_stall, "input taken while a word is in flight")

  // a result only appears at the end of work on a word
  `SDLF_ASSERT_SAME(a_result_from_work, clk, rst, $rose(result_valid), $past(item_stall), "result word without work")

  // reset empties the output register
  `SDLF_ASSERT_ALWAYS(a_reset_empty, clk, rst, !result_valid, "result valid after reset")

endmodule

bind shape_dynamics_logistic_filter sdlf_checker u_sdlf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
